[design/assert_macros.svh]
// assertion helper macros for the swerve kinematics block
// needs clk and rst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SDK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen
`define SDK_NEVER(lbl, cond, msg) \
  `SDK_ASSERT(lbl, !(cond), msg)

`endif

[design/sdk_pkg.sv]
// shared types, widths and constants of the swerve kinematics block
// no dependencies
`default_nettype none

package sdk_pkg;

  localparam int VEL_W   = 16;
  localparam int RE_W    = 21;
  localparam int THR_W   = 17;
  localparam int VX_W    = 18;
  localparam int LX_W    = 24;
  localparam int CW      = 40;
  localparam int ZW      = 22;
  localparam int MAG_W   = 24;
  localparam int SC_W    = 31;
  localparam int NUM_W   = 41;
  localparam int ACC_W   = 64;
  localparam int MA_W    = 33;
  localparam int MB_W    = 25;
  localparam int PR_W    = 58;
  localparam int ANG_W   = 18;
  localparam int Q_W     = 20;
  localparam int IT_W    = 5;
  localparam int DIV_W   = 5;
  localparam int GAIN_W  = 16;
  localparam int TPT_W   = 20;
  localparam int CFG_W   = 64;
  localparam int CORDIC_ITERS = 18;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [IT_W-1:0]  LAST_ITER = IT_W'(CORDIC_ITERS - 1);
  localparam logic [DIV_W-1:0] DIV0_CNT  = 5'd31;
  localparam logic [DIV_W-1:0] DIVS_CNT  = 5'd17;
  localparam logic [23:0]      CORDIC_K  = 24'd10188014;

  // configuration register indexes
  localparam logic [1:0] REG_OFFX = 2'd0;
  localparam logic [1:0] REG_OFFY = 2'd1;
  localparam logic [1:0] REG_GAIN = 2'd2;
  localparam logic [1:0] REG_TPT  = 2'd3;

  // k-multiply targets
  localparam logic [1:0] KS_VX  = 2'd0;
  localparam logic [1:0] KS_VY  = 2'd1;
  localparam logic [1:0] KS_MAG = 2'd2;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [RE_W-1:0]  rot_eff;
    logic [THR_W-1:0]        throttle;
    logic                    field_centric;
    logic signed [VEL_W-1:0] yaw;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [4:0] {
    B_IDLE, B_SCALE0, B_DIV, B_FC, B_CORDIC, B_KLO, B_KHI, B_KSUM, B_KRES,
    B_OFFY, B_OFFX, B_LY, B_VEC, B_ANG1, B_ANG2, B_TICK, B_TICK2, B_SPD, B_OUT
  } back_state_t;

  // arctangent of 2^-i in 2^-20 turn
  function automatic logic [17:0] atan_val(input logic [IT_W-1:0] i);
    logic [17:0] v;
    case (i)
      5'd0:    v = 18'd131072;
      5'd1:    v = 18'd77376;
      5'd2:    v = 18'd40884;
      5'd3:    v = 18'd20753;
      5'd4:    v = 18'd10417;
      5'd5:    v = 18'd5213;
      5'd6:    v = 18'd2607;
      5'd7:    v = 18'd1304;
      5'd8:    v = 18'd652;
      5'd9:    v = 18'd326;
      5'd10:   v = 18'd163;
      5'd11:   v = 18'd81;
      5'd12:   v = 18'd41;
      5'd13:   v = 18'd20;
      5'd14:   v = 18'd10;
      5'd15:   v = 18'd5;
      5'd16:   v = 18'd3;
      5'd17:   v = 18'd1;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/swerve_drive_kinematics_top.sv]
// top level of the swerve drive inverse kinematics block
// depends on sdk_pkg, sdk_front, sdk_fifo, sdk_back
//
//   port group   direction   handshake            moves
//   in_*         in          in_valid / in_stall  one drive command per transfer
//   out_*        out         out_valid / out_stall one wheel result per transfer
//   cfg_*        in          cfg_we               one register write
//
// a command computes the throttle reciprocal (one bit a cycle), plus,
// when field-centric, 18 cordic steps and two split multiplies, plus
// per wheel 18 cordic steps and a 17-bit speed divide; a zero
// wheel vector skips its cordic.
// reset is synchronous and active low; it clears the kept steering angles
// a two-entry queue lets new commands be taken while the back end works;
// the result register lets work go on to the next wheel while out_stall is high
`default_nettype none

module swerve_drive_kinematics_top #(
  parameter int NUM_WHEELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_vel_x,
  input  wire logic signed [15:0] in_vel_y,
  input  wire logic signed [15:0] in_rot_rate,
  input  wire logic [16:0]        in_throttle,
  input  wire logic               in_field_centric,
  input  wire logic signed [15:0] in_yaw,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_wheel_index,
  output logic signed [31:0]      out_steer_ticks,
  output logic signed [15:0]      out_wheel_speed,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata
);

  // configuration registers
  logic [63:0]                    offx_r, offy_r;
  logic [sdk_pkg::GAIN_W-1:0]     gain_r;
  logic [sdk_pkg::TPT_W-1:0]      tpt_r;

  // front to queue to back
  logic                           push, pop;
  sdk_pkg::cmd_t                  push_data, pop_data;
  sdk_pkg::fifo_stat_t            fifo_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r <= '0;
      offy_r <= '0;
      gain_r <= 16'd4096;
      tpt_r  <= 20'd26214;
    end else if (cfg_we) begin
      case (cfg_index)
        sdk_pkg::REG_OFFX: offx_r <= cfg_wdata;
        sdk_pkg::REG_OFFY: offy_r <= cfg_wdata;
        sdk_pkg::REG_GAIN: gain_r <= cfg_wdata[sdk_pkg::GAIN_W-1:0];
        sdk_pkg::REG_TPT:  tpt_r  <= cfg_wdata[sdk_pkg::TPT_W-1:0];
        default: ;
      endcase
    end
  end

  // accepts commands and applies the rotation gain
  sdk_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_rot_rate      (in_rot_rate),
    .in_throttle      (in_throttle),
    .in_field_centric (in_field_centric),
    .in_yaw           (in_yaw),
    .rotation_gain    (gain_r),
    .fifo_stat        (fifo_stat),
    .push             (push),
    .push_data        (push_data)
  );

  // decouples the front from the long per-command sequence
  sdk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .stat      (fifo_stat),
    .pop_data  (pop_data)
  );

  // kinematics sequencer and result register
  sdk_back #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_stat       (fifo_stat),
    .fifo_data       (pop_data),
    .pop             (pop),
    .offsets_x       (offx_r),
    .offsets_y       (offy_r),
    .ticks_per_turn  (tpt_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wheel_index (out_wheel_index),
    .out_steer_ticks (out_steer_ticks),
    .out_wheel_speed (out_wheel_speed),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

[design/sdk_front.sv]
// front end: takes drive commands, scales the rotation rate, feeds the queue
// depends on sdk_pkg
`default_nettype none

module sdk_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              in_vel_x,
  input  wire logic signed [15:0]              in_vel_y,
  input  wire logic signed [15:0]              in_rot_rate,
  input  wire logic [16:0]                     in_throttle,
  input  wire logic                            in_field_centric,
  input  wire logic signed [15:0]              in_yaw,
  input  wire logic [sdk_pkg::GAIN_W-1:0]      rotation_gain,
  input  wire sdk_pkg::fifo_stat_t             fifo_stat,
  output logic                                 push,
  output sdk_pkg::cmd_t                        push_data
);

  logic                    st_v_r;
  logic signed [15:0]      vx_r, vy_r, rot_r, yaw_r;
  logic [16:0]             thr_r;
  logic                    fc_r;
  logic                    accept;
  logic signed [32:0]      rg_prod, rg_rnd;

  assign in_stall = st_v_r && fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = st_v_r && !fifo_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else if (accept) begin
      st_v_r <= 1'b1;
    end else if (push) begin
      st_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r  <= in_vel_x;
      vy_r  <= in_vel_y;
      rot_r <= in_rot_rate;
      thr_r <= in_throttle;
      fc_r  <= in_field_centric;
      yaw_r <= in_yaw;
    end
  end

  // rotation rate times gain, rounded back to q.14
  always_comb begin
    rg_prod = rot_r * $signed({1'b0, rotation_gain});
    rg_rnd  = rg_prod + 33'sd2048;
    push_data.vel_x         = vx_r;
    push_data.vel_y         = vy_r;
    push_data.rot_eff       = rg_rnd[32:12];
    push_data.throttle      = thr_r;
    push_data.field_centric = fc_r;
    push_data.yaw           = yaw_r;
  end

endmodule

`default_nettype wire

[design/sdk_fifo.sv]
// short command queue between front and back end
// depends on sdk_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdk_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sdk_pkg::cmd_t        push_data,
  input  wire logic                 pop,
  output sdk_pkg::fifo_stat_t       stat,
  output sdk_pkg::cmd_t             pop_data
);

  localparam int PW = $clog2(sdk_pkg::FIFO_DEPTH);

  sdk_pkg::cmd_t   mem_r [sdk_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign stat.full  = (cnt_r == (PW+1)'(sdk_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(sdk_pkg::FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(sdk_pkg::FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  `SDK_NEVER(a_pop_empty, pop && stat.empty, "queue popped while empty")
  `SDK_NEVER(a_push_full, push && stat.full, "queue pushed while full")

endmodule

`default_nettype wire

[design/sdk_back.sv]
// back end: field-centric rotation, per-wheel cordic, steering and speed
// depends on sdk_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdk_back #(
  parameter int NUM_WHEELS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sdk_pkg::fifo_stat_t         fifo_stat,
  input  wire sdk_pkg::cmd_t               fifo_data,
  output logic                             pop,
  input  wire logic [63:0]                 offsets_x,
  input  wire logic [63:0]                 offsets_y,
  input  wire logic [sdk_pkg::TPT_W-1:0]   ticks_per_turn,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_wheel_index,
  output logic signed [31:0]               out_steer_ticks,
  output logic signed [15:0]               out_wheel_speed,
  output logic                             out_last
);

  localparam int WW = $clog2(NUM_WHEELS);
  localparam logic signed [sdk_pkg::ACC_W-1:0] RND39 = 64'sd549755813888;
  localparam logic signed [sdk_pkg::ACC_W-1:0] RND35 = 64'sd34359738368;

  sdk_pkg::back_state_t state_r, state_nxt;
  sdk_pkg::cmd_t        cmd_r;

  logic [WW-1:0]                      w_r;
  logic [2:0]                         w3;
  logic                               wlast;
  logic [sdk_pkg::IT_W-1:0]           iter_r;
  logic                               mode_rot_r;
  logic [1:0]                         ksel_r;
  logic signed [sdk_pkg::CW-1:0]      a_r, b_r;
  logic signed [sdk_pkg::ZW-1:0]      z_r;
  logic signed [sdk_pkg::VX_W-1:0]    vx_r, vy_r;
  logic signed [sdk_pkg::LX_W-1:0]    lx_r, ly_r;
  logic [sdk_pkg::MAG_W-1:0]          mag_r;
  logic [sdk_pkg::SC_W-1:0]           scale_r;
  logic signed [sdk_pkg::ANG_W-1:0]   ang_r;
  logic signed [sdk_pkg::Q_W-1:0]     q_r;
  logic signed [31:0]                 na_r;
  logic signed [sdk_pkg::PR_W-1:0]    prod_r;
  logic signed [sdk_pkg::ACC_W-1:0]   acc_r;
  logic [sdk_pkg::SC_W-1:0]           rem_r;
  logic [sdk_pkg::NUM_W-1:0]          num_r;
  logic [sdk_pkg::DIV_W-1:0]          div_cnt_r;
  logic                               div_kind_r;
  logic signed [15:0]                 spd_r;

  logic signed [31:0]                 steer_r [NUM_WHEELS];
  logic signed [31:0]                 tick_r  [NUM_WHEELS];
  logic [sdk_pkg::MAG_W-1:0]          magw_r  [NUM_WHEELS];
  logic                               neg_r   [NUM_WHEELS];

  logic                               out_valid_r, out_last_r;
  logic [1:0]                         out_wi_r;
  logic signed [31:0]                 out_ticks_r;
  logic signed [15:0]                 out_speed_r;
  logic                               out_free, out_load;

  // cordic step
  logic signed [sdk_pkg::CW-1:0]      sa, sb, a_n, b_n;
  logic signed [sdk_pkg::ZW-1:0]      tab, z_n;
  logic                               dir;
  // cordic setup
  logic signed [sdk_pkg::CW-1:0]      ra0, rb0, va0, vb0;
  logic signed [sdk_pkg::ZW-1:0]      rz0, vz0;
  // divider step
  logic [sdk_pkg::SC_W:0]             dt, dden;
  logic                               dge;
  logic [sdk_pkg::SC_W-1:0]           rem_n;
  logic [sdk_pkg::NUM_W-1:0]          num_n;
  logic [sdk_pkg::NUM_W-1:0]          nsp;
  logic [16:0]                        dq;
  logic signed [15:0]                 spd_c;
  // multiplier
  logic signed [sdk_pkg::CW-1:0]      kx, kx_hi;
  logic signed [sdk_pkg::MA_W-1:0]    mul_a;
  logic signed [sdk_pkg::MB_W-1:0]    mul_b;
  logic signed [15:0]                 offx_s, offy_s;
  logic signed [sdk_pkg::PR_W-1:0]    rnd14, rnd16, tsh;
  logic signed [sdk_pkg::LX_W-1:0]    off_term;
  // angle
  logic signed [20:0]                 zr8, zsh;
  logic signed [sdk_pkg::ANG_W-1:0]   ang_c;
  logic signed [33:0]                 rdiff;
  logic signed [18:0]                 q0;
  logic                               qinc;
  logic signed [sdk_pkg::Q_W-1:0]     q_c;
  logic signed [47:0]                 naf;
  logic signed [31:0]                 na_c;
  logic                               vec_zero, thr_zero;

  assign w3       = 3'(w_r);
  assign wlast    = (w_r == WW'(NUM_WHEELS - 1));
  assign thr_zero = (cmd_r.throttle == '0);
  assign vec_zero = (lx_r == '0) && (ly_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  // offsets, zero past the fourth wheel
  always_comb begin
    offx_s = '0;
    offy_s = '0;
    if (w3 < 3'd4) begin
      offx_s = offsets_x[{w3[1:0], 4'b0} +: 16];
      offy_s = offsets_y[{w3[1:0], 4'b0} +: 16];
    end
  end

  // shared cordic iteration
  always_comb begin
    sa  = a_r >>> iter_r;
    sb  = b_r >>> iter_r;
    tab = $signed({4'b0, sdk_pkg::atan_val(iter_r)});
    dir = mode_rot_r ? !z_r[sdk_pkg::ZW-1] : b_r[sdk_pkg::CW-1];
    if (dir) begin
      a_n = a_r - sb;
      b_n = b_r + sa;
      z_n = z_r - tab;
    end else begin
      a_n = a_r + sb;
      b_n = b_r - sa;
      z_n = z_r + tab;
    end
  end

  // rotation and vectoring setup with half-turn prefold
  always_comb begin
    ra0 = sdk_pkg::CW'(cmd_r.vel_x) <<< 16;
    rb0 = sdk_pkg::CW'(cmd_r.vel_y) <<< 16;
    rz0 = sdk_pkg::ZW'(cmd_r.yaw) <<< 4;
    if (rz0 > 22'sd262144) begin
      ra0 = -ra0;
      rb0 = -rb0;
      rz0 = rz0 - 22'sd524288;
    end else if (rz0 < -22'sd262144) begin
      ra0 = -ra0;
      rb0 = -rb0;
      rz0 = rz0 + 22'sd524288;
    end
    va0 = sdk_pkg::CW'(lx_r) <<< 12;
    vb0 = sdk_pkg::CW'(ly_r) <<< 12;
    vz0 = '0;
    if (lx_r < 0) begin
      va0 = -va0;
      vb0 = -vb0;
      vz0 = 22'sd524288;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    dden  = div_kind_r ? {1'b0, scale_r}
                       : {{(sdk_pkg::SC_W + 1 - sdk_pkg::THR_W){1'b0}}, cmd_r.throttle};
    dt    = {rem_r, num_r[sdk_pkg::NUM_W-1]};
    dge   = (dt >= dden);
    rem_n = dge ? sdk_pkg::SC_W'(dt - dden) : dt[sdk_pkg::SC_W-1:0];
    num_n = {num_r[sdk_pkg::NUM_W-2:0], dge};
    dq    = num_n[16:0];
    if (neg_r[w_r]) begin
      spd_c = 16'(-$signed({1'b0, dq}));
    end else if (dq > 17'd32767) begin
      spd_c = 16'sd32767;
    end else begin
      spd_c = $signed(dq[15:0]);
    end
    nsp = sdk_pkg::NUM_W'({magw_r[w_r], 15'b0}) + sdk_pkg::NUM_W'(scale_r >> 1);
  end

  // shared multiplier operands
  always_comb begin
    kx    = (ksel_r == sdk_pkg::KS_VY) ? b_r : a_r;
    kx_hi = kx >>> 18;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      sdk_pkg::B_KLO: begin
        mul_a = $signed({{(sdk_pkg::MA_W - 18){1'b0}}, kx[17:0]});
        mul_b = $signed({1'b0, sdk_pkg::CORDIC_K});
      end
      sdk_pkg::B_KHI: begin
        mul_a = sdk_pkg::MA_W'(kx_hi);
        mul_b = $signed({1'b0, sdk_pkg::CORDIC_K});
      end
      sdk_pkg::B_OFFY: begin
        mul_a = sdk_pkg::MA_W'(cmd_r.rot_eff);
        mul_b = sdk_pkg::MB_W'(offy_s);
      end
      sdk_pkg::B_OFFX: begin
        mul_a = sdk_pkg::MA_W'(cmd_r.rot_eff);
        mul_b = sdk_pkg::MB_W'(offx_s);
      end
      sdk_pkg::B_TICK: begin
        mul_a = sdk_pkg::MA_W'(na_r);
        mul_b = $signed({{(sdk_pkg::MB_W - sdk_pkg::TPT_W){1'b0}}, ticks_per_turn});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    rnd14    = prod_r + 58'sd8192;
    off_term = $signed(rnd14[37:14]);
    rnd16    = prod_r + 58'sd32768;
    tsh      = rnd16 >>> 16;
  end

  // steering: nearest equivalent angle modulo a half turn
  always_comb begin
    zr8   = $signed({z_r[19], z_r[19:0]}) + 21'sd8;
    zsh   = zr8 >>> 4;
    ang_c = -sdk_pkg::ANG_W'(zsh);
    rdiff = 34'(steer_r[w_r]) - 34'(ang_c);
    q0    = rdiff[33:15];
    qinc  = (rdiff[14:0] > 15'd16384) || ((rdiff[14:0] == 15'd16384) && q0[0]);
    q_c   = sdk_pkg::Q_W'(q0) + $signed({{(sdk_pkg::Q_W - 1){1'b0}}, qinc});
    naf   = 48'(ang_r) + (48'(q_r) <<< 15);
    na_c  = sdk_pkg::sat32(naf);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdk_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      sdk_pkg::B_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          state_nxt = sdk_pkg::B_SCALE0;
        end
      end
      sdk_pkg::B_SCALE0: state_nxt = thr_zero ? sdk_pkg::B_FC : sdk_pkg::B_DIV;
      sdk_pkg::B_DIV: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = div_kind_r ? sdk_pkg::B_OUT : sdk_pkg::B_FC;
        end
      end
      sdk_pkg::B_FC: state_nxt = cmd_r.field_centric ? sdk_pkg::B_CORDIC : sdk_pkg::B_OFFY;
      sdk_pkg::B_CORDIC: begin
        if (iter_r == sdk_pkg::LAST_ITER) begin
          state_nxt = sdk_pkg::B_KLO;
        end
      end
      sdk_pkg::B_KLO:  state_nxt = sdk_pkg::B_KHI;
      sdk_pkg::B_KHI:  state_nxt = sdk_pkg::B_KSUM;
      sdk_pkg::B_KSUM: state_nxt = sdk_pkg::B_KRES;
      sdk_pkg::B_KRES: begin
        case (ksel_r)
          sdk_pkg::KS_VX: state_nxt = sdk_pkg::B_KLO;
          sdk_pkg::KS_VY: state_nxt = sdk_pkg::B_OFFY;
          default:        state_nxt = sdk_pkg::B_ANG1;
        endcase
      end
      sdk_pkg::B_OFFY: state_nxt = sdk_pkg::B_OFFX;
      sdk_pkg::B_OFFX: state_nxt = sdk_pkg::B_LY;
      sdk_pkg::B_LY:   state_nxt = sdk_pkg::B_VEC;
      sdk_pkg::B_VEC:  state_nxt = vec_zero ? sdk_pkg::B_ANG1 : sdk_pkg::B_CORDIC;
      sdk_pkg::B_ANG1: state_nxt = sdk_pkg::B_ANG2;
      sdk_pkg::B_ANG2: state_nxt = sdk_pkg::B_TICK;
      sdk_pkg::B_TICK: state_nxt = sdk_pkg::B_TICK2;
      sdk_pkg::B_TICK2: state_nxt = wlast ? sdk_pkg::B_SPD : sdk_pkg::B_OFFY;
      sdk_pkg::B_SPD:  state_nxt = thr_zero ? sdk_pkg::B_OUT : sdk_pkg::B_DIV;
      sdk_pkg::B_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = wlast ? sdk_pkg::B_IDLE : sdk_pkg::B_SPD;
        end
      end
      default: state_nxt = sdk_pkg::B_IDLE;
    endcase
  end

  // wheel counter and kept steering angles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        steer_r[i] <= '0;
      end
    end else begin
      if (state_r == sdk_pkg::B_ANG2) begin
        steer_r[w_r] <= na_c;
      end
      if ((state_r == sdk_pkg::B_TICK2) || ((state_r == sdk_pkg::B_OUT) && out_free)) begin
        w_r <= wlast ? '0 : w_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      sdk_pkg::B_IDLE: begin
        if (pop) begin
          cmd_r <= fifo_data;
        end
      end
      sdk_pkg::B_SCALE0: begin
        scale_r    <= '0;
        rem_r      <= '0;
        num_r      <= {1'b1, {(sdk_pkg::NUM_W - 1){1'b0}}};
        div_cnt_r  <= sdk_pkg::DIV0_CNT;
        div_kind_r <= 1'b0;
      end
      sdk_pkg::B_DIV: begin
        rem_r     <= rem_n;
        num_r     <= num_n;
        div_cnt_r <= div_cnt_r - 1'b1;
        if (div_cnt_r == 5'd1) begin
          if (div_kind_r) begin
            spd_r <= spd_c;
          end else begin
            scale_r <= num_n[sdk_pkg::SC_W-1:0];
          end
        end
      end
      sdk_pkg::B_FC: begin
        vx_r       <= sdk_pkg::VX_W'(cmd_r.vel_x);
        vy_r       <= sdk_pkg::VX_W'(cmd_r.vel_y);
        a_r        <= ra0;
        b_r        <= rb0;
        z_r        <= rz0;
        iter_r     <= '0;
        mode_rot_r <= 1'b1;
        ksel_r     <= sdk_pkg::KS_VX;
      end
      sdk_pkg::B_CORDIC: begin
        a_r    <= a_n;
        b_r    <= b_n;
        z_r    <= z_n;
        iter_r <= iter_r + 1'b1;
      end
      sdk_pkg::B_KHI: acc_r <= sdk_pkg::ACC_W'(prod_r);
      sdk_pkg::B_KSUM: begin
        acc_r <= acc_r + (sdk_pkg::ACC_W'(prod_r) <<< 18)
                 + ((ksel_r == sdk_pkg::KS_MAG) ? RND35 : RND39);
      end
      sdk_pkg::B_KRES: begin
        case (ksel_r)
          sdk_pkg::KS_VX: begin
            vx_r   <= acc_r[57:40];
            ksel_r <= sdk_pkg::KS_VY;
          end
          sdk_pkg::KS_VY: vy_r <= acc_r[57:40];
          default:        mag_r <= acc_r[59:36];
        endcase
      end
      sdk_pkg::B_OFFX: lx_r <= sdk_pkg::LX_W'(vx_r) + off_term;
      sdk_pkg::B_LY:   ly_r <= sdk_pkg::LX_W'(vy_r) - off_term;
      sdk_pkg::B_VEC: begin
        if (vec_zero) begin
          z_r   <= '0;
          mag_r <= '0;
        end else begin
          a_r        <= va0;
          b_r        <= vb0;
          z_r        <= vz0;
          iter_r     <= '0;
          mode_rot_r <= 1'b0;
          ksel_r     <= sdk_pkg::KS_MAG;
        end
      end
      sdk_pkg::B_ANG1: begin
        ang_r <= ang_c;
        q_r   <= q_c;
      end
      sdk_pkg::B_ANG2: begin
        na_r        <= na_c;
        magw_r[w_r] <= mag_r;
        neg_r[w_r]  <= !q_r[0];
        if ({{(sdk_pkg::SC_W - sdk_pkg::MAG_W){1'b0}}, mag_r} > scale_r) begin
          scale_r <= {{(sdk_pkg::SC_W - sdk_pkg::MAG_W){1'b0}}, mag_r};
        end
      end
      sdk_pkg::B_TICK2: tick_r[w_r] <= sdk_pkg::sat32(48'(tsh));
      sdk_pkg::B_SPD: begin
        spd_r      <= '0;
        rem_r      <= sdk_pkg::SC_W'(nsp[sdk_pkg::NUM_W-1:17]);
        num_r      <= {nsp[16:0], {(sdk_pkg::NUM_W - 17){1'b0}}};
        div_cnt_r  <= sdk_pkg::DIVS_CNT;
        div_kind_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wi_r    <= w3[1:0];
      out_ticks_r <= tick_r[w_r];
      out_speed_r <= spd_r;
      out_last_r  <= wlast;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_index = out_wi_r;
  assign out_steer_ticks = out_ticks_r;
  assign out_wheel_speed = out_speed_r;
  assign out_last        = out_last_r;

  `SDK_ASSERT(a_iter_range, (state_r == sdk_pkg::B_CORDIC) |-> (iter_r <= sdk_pkg::LAST_ITER),
    "cordic iteration count out of range")
  `SDK_NEVER(a_div_cnt, (state_r == sdk_pkg::B_DIV) && (div_cnt_r == '0),
    "divider running with no bits left")
  `SDK_ASSERT(a_idle_wheel, (state_r == sdk_pkg::B_IDLE) |-> (w_r == '0),
    "wheel counter not rewound between commands")

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for swerve_drive_kinematics_top: directed and random
// drive commands checked wheel by wheel against an in-bench kinematics predictor
// depends on sdk_pkg and the block's rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWHEEL = 4;
  localparam int SETTLE = 300;   // a bit over one full command through the back end

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] rot;
    logic [16:0]        thr;
    logic               fc;
    logic signed [15:0] yaw;
  } drive_cmd_t;

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] ticks;
    logic signed [15:0] speed;
    logic               last;
  } wheel_res_t;

  // dut connections
  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic signed [15:0] in_vel_x, in_vel_y, in_rot_rate, in_yaw;
  logic [16:0]        in_throttle;
  logic               in_field_centric;
  logic               out_valid, out_stall;
  logic [1:0]         out_wheel_index;
  logic signed [31:0] out_steer_ticks;
  logic signed [15:0] out_wheel_speed;
  logic               out_last;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [63:0]        cfg_wdata;

  swerve_drive_kinematics_top #(.NUM_WHEELS(NWHEEL)) DUT (.*);

  // predictor state: register copies and kept steering angles
  logic [63:0] offx_reg, offy_reg;
  logic [15:0] gain_reg;
  logic [19:0] tpt_reg;
  int          steer_acc [NWHEEL];

  drive_cmd_t pending_cmds[$];
  wheel_res_t expected_wheels[$];
  int         err_count = 0;
  int         cmds_sent = 0;
  int         cmds_taken = 0;
  int         wheels_seen = 0;
  bit         cmd_took = 0;
  bit         long_hold_req = 0;
  int         atan_lut [18] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                                652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // cordic rotation, z in 2^-20 turn, gain left in
  function automatic void rot_cordic(inout longint a, inout longint b, input longint z);
    longint sa, sb;
    if (z > 262144) begin
      a = -a; b = -b; z -= 524288;
    end else if (z < -262144) begin
      a = -a; b = -b; z += 524288;
    end
    for (int i = 0; i < 18; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (z >= 0) begin
        a -= sb; b += sa; z -= atan_lut[i];
      end else begin
        a += sb; b -= sa; z += atan_lut[i];
      end
    end
  endfunction

  // cordic vectoring, returns angle wrapped to 20 bits; a ends as scaled magnitude
  function automatic longint vec_cordic(inout longint a, input longint b);
    longint sa, sb, z;
    logic signed [19:0] zw;
    z = 0;
    if (a < 0) begin
      a = -a; b = -b; z = 524288;
    end
    for (int i = 0; i < 18; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (b >= 0) begin
        a += sb; b -= sa; z += atan_lut[i];
      end else begin
        a -= sb; b += sa; z -= atan_lut[i];
      end
    end
    zw = z[19:0];
    return zw;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // works out the four wheel results of one command and updates the kept angles
  function automatic void predict_wheels(drive_cmd_t c);
    longint vx, vy, re, scale, thr, gx, gy, lx, ly, mag, z, ang, r, q, frac, na, m, s;
    longint spd [NWHEEL];
    longint tick [NWHEEL];
    wheel_res_t w;
    vx = c.vx; vy = c.vy; thr = c.thr;
    if (c.fc) begin
      gx = vx * 65536;
      gy = vy * 65536;
      rot_cordic(gx, gy, longint'(c.yaw) * 16);
      vx = (gx * 10188014 + (64'sd1 <<< 39)) >>> 40;
      vy = (gy * 10188014 + (64'sd1 <<< 39)) >>> 40;
    end
    re = (longint'(c.rot) * longint'(gain_reg) + 2048) >>> 12;
    scale = (thr != 0) ? (64'sd1 <<< 30) / thr : 0;
    for (int i = 0; i < NWHEEL; i++) begin
      lx = vx + ((longint'($signed(offy_reg[16*i +: 16])) * re + 8192) >>> 14);
      ly = vy - ((longint'($signed(offx_reg[16*i +: 16])) * re + 8192) >>> 14);
      mag = 0;
      z = 0;
      // zero vector keeps angle and magnitude at zero
      if (lx != 0 || ly != 0) begin
        gx = lx * 4096;
        z = vec_cordic(gx, ly * 4096);
        mag = (gx * 10188014 + (64'sd1 <<< 35)) >>> 36;
      end
      ang = -((z + 8) >>> 4);
      r = longint'(steer_acc[i]) - ang;
      q = r >>> 15;
      frac = r - q * 32768;
      if (frac > 16384 || (frac == 16384 && q[0])) q++;
      na = clip32(ang + q * 32768);
      steer_acc[i] = int'(na);
      spd[i] = q[0] ? mag : -mag;
      tick[i] = clip32((longint'(tpt_reg) * na + 32768) >>> 16);
      if (mag > scale) scale = mag;
    end
    for (int i = 0; i < NWHEEL; i++) begin
      s = 0;
      if (thr != 0 && scale > 0) begin
        m = spd[i] < 0 ? -spd[i] : spd[i];
        s = (m * 32768 + scale / 2) / scale;
        if (spd[i] < 0) s = -s;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
      end
      w.idx = i[1:0];
      w.ticks = tick[i][31:0];
      w.speed = s[15:0];
      w.last = (i == NWHEEL - 1);
      expected_wheels.push_back(w);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("MISMATCH %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // monitor: transfers are seen at the rising edge
  always @(posedge clk) begin
    wheel_res_t w;
    cmd_took = rst_n && in_valid && !in_stall;
    if (cmd_took) begin
      drive_cmd_t c;
      c.vx = in_vel_x; c.vy = in_vel_y; c.rot = in_rot_rate;
      c.thr = in_throttle; c.fc = in_field_centric; c.yaw = in_yaw;
      cmds_taken++;
      predict_wheels(c);
    end
    if (rst_n && out_valid && !out_stall) begin
      wheels_seen++;
      if (expected_wheels.size() == 0) begin
        report_mismatch("unexpected result transfer, wheel", out_wheel_index, -1);
      end else begin
        w = expected_wheels.pop_front();
        if (out_wheel_index !== w.idx) report_mismatch("wheel_index", out_wheel_index, w.idx);
        if (out_steer_ticks !== w.ticks)
          report_mismatch("steer_ticks", out_steer_ticks, w.ticks);
        if (out_wheel_speed !== w.speed)
          report_mismatch("wheel_speed", out_wheel_speed, w.speed);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // driver: a stalled command holds, otherwise the next one after a gap
  int send_gap = 0;
  always @(negedge clk) begin
    drive_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !cmd_took) begin
      // still waiting for the transfer, payload stays put
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      in_vel_x <= c.vx; in_vel_y <= c.vy; in_rot_rate <= c.rot;
      in_throttle <= c.thr; in_field_centric <= c.fc; in_yaw <= c.yaw;
      in_valid <= 1'b1;
      cmds_sent++;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off on request so the queue backs up
  int hold_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      long_hold_req = 0;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sdk_pkg::REG_OFFX: offx_reg = val;
      sdk_pkg::REG_OFFY: offy_reg = val;
      sdk_pkg::REG_GAIN: gain_reg = val[15:0];
      sdk_pkg::REG_TPT:  tpt_reg = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cmd(int vx, int vy, int rot, int thr, int fc, int yaw);
    drive_cmd_t c;
    c.vx = 16'(vx); c.vy = 16'(vy); c.rot = 16'(rot); c.thr = 17'(thr);
    c.fc = 1'(fc); c.yaw = 16'(yaw);
    pending_cmds.push_back(c);
  endtask

  // mostly ordinary commands, some zero vectors and extreme values mixed in
  task automatic queue_random(int n);
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < 8)
        queue_cmd(0, 0, 0, $urandom_range(1, 65536), $urandom_range(1), $urandom);
      else if (p < 14)
        queue_cmd($urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 32767 : -32768,
                  $urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 1 : 65536,
                  $urandom_range(1), $urandom_range(1) ? 32767 : -32768);
      else
        queue_cmd($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                  $urandom_range(1, 65536), $urandom_range(1), $signed(16'($urandom)));
    end
  endtask

  // wait until every command is through and every result has come, then settle
  task automatic drain();
    wait (pending_cmds.size() == 0 && cmds_taken == cmds_sent && !in_valid &&
          expected_wheels.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = sdk_pkg::REG_OFFX; cfg_wdata = '0;
    in_vel_x = 0; in_vel_y = 0; in_rot_rate = 0; in_throttle = 17'd65536;
    in_field_centric = 0; in_yaw = 0;
    offx_reg = '0; offy_reg = '0; gain_reg = 16'd4096; tpt_reg = 20'd26214;
    foreach (steer_acc[i]) steer_acc[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // typical four-corner layout
    write_reg(sdk_pkg::REG_OFFX, {16'shE000, 16'sh2000, 16'shE000, 16'sh2000});
    write_reg(sdk_pkg::REG_OFFY, {16'shE000, 16'shE000, 16'sh2000, 16'sh2000});
    write_reg(sdk_pkg::REG_GAIN, 64'd4096);
    write_reg(sdk_pkg::REG_TPT, 64'd26214);

    // directed: zero vector, throttle extremes and zero, field extremes, yaw wrap
    queue_cmd(0, 0, 0, 65536, 0, 0);
    queue_cmd(16384, 0, 0, 65536, 0, 0);
    queue_cmd(-16384, 0, 0, 65536, 0, 0);
    queue_cmd(0, 16384, 0, 65536, 0, 0);
    queue_cmd(0, -16384, 0, 1, 0, 0);
    queue_cmd(32767, 32767, 32767, 65536, 0, 0);
    queue_cmd(-32768, -32768, -32768, 65536, 0, 0);
    queue_cmd(4000, 3000, 0, 0, 0, 0);
    queue_cmd(4000, 3000, 0, 131071, 0, 0);
    queue_cmd(0, 0, 16384, 32768, 0, 0);
    queue_cmd(16384, 0, 0, 65536, 1, 16384);
    queue_cmd(16384, 0, 0, 65536, 1, 32767);
    queue_cmd(16384, 0, 0, 65536, 1, -32768);
    queue_cmd(-32768, 32767, 0, 65536, 1, -16384);
    queue_cmd(-16384, 1, 0, 65536, 0, 0);
    queue_cmd(-16384, -1, 0, 65536, 0, 0);
    queue_cmd(1, 0, -1, 3, 1, 1);
    drain();

    // random part in phases with different register settings, extremes included
    long_hold_req = 1;
    queue_random(80);
    drain();

    write_reg(sdk_pkg::REG_OFFX, 64'h7FFF_8000_7FFF_8000);
    write_reg(sdk_pkg::REG_OFFY, 64'h8000_7FFF_8000_7FFF);
    write_reg(sdk_pkg::REG_GAIN, 64'd65535);
    write_reg(sdk_pkg::REG_TPT, 64'd1048575);
    queue_random(80);
    drain();

    write_reg(sdk_pkg::REG_OFFX, 64'h0);
    write_reg(sdk_pkg::REG_OFFY, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(sdk_pkg::REG_GAIN, 64'd0);
    write_reg(sdk_pkg::REG_TPT, 64'd1);
    queue_random(80);
    drain();

    write_reg(sdk_pkg::REG_OFFX, {$urandom, $urandom});
    write_reg(sdk_pkg::REG_OFFY, {$urandom, $urandom});
    write_reg(sdk_pkg::REG_GAIN, 64'($urandom_range(65535)));
    write_reg(sdk_pkg::REG_TPT, 64'($urandom_range(1, 1048575)));
    queue_random(80);
    drain();

    $display("covered %0d drive commands and %0d wheel results over four register settings",
             cmds_sent, wheels_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_wheels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+design
design/sdk_pkg.sv
design/sdk_front.sv
design/sdk_fifo.sv
design/sdk_back.sv
design/swerve_drive_kinematics_top.sv
bench/tb.sv
